### rtl/bdasc_pkg.sv
// Package of the binary to decimal ASCII converter.
// Holds the cell operation codes, the sequencer states and the fixed field widths.
// Depends on nothing; every other file of the block refers to it by scoped names.
package bdasc_pkg;

    localparam int VALUE_BITS = 64;
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int COUNT_W    = 5;
    localparam int CHAR_W     = 6;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DABBLE,
        OP_SHIFT_UP
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_EMIT
    } state_t;

    // Command broadcast to every cell of the digit row.
    typedef struct packed {
        cell_op_t op;
        logic     shift_bit;
    } cell_ctrl_t;

    // What one cell hands to the cell above it.
    typedef struct packed {
        logic [3:0] digit;
        logic       carry;
    } cell_link_t;

endpackage

### rtl/bdasc_num_if.sv
// Input channel of the converter: one unsigned 64-bit number per transfer.
// Depends on bdasc_pkg for the value width.
interface bdasc_num_if;
    logic                               valid;
    logic                               ready;
    logic [bdasc_pkg::VALUE_BITS-1:0]   value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### rtl/bdasc_text_if.sv
// Output channel of the converter: one ASCII digit character per transfer.
// Depends on bdasc_pkg for the field widths.
interface bdasc_text_if;
    logic                               valid;
    logic                               ready;
    logic [bdasc_pkg::CHAR_W-1:0]       ascii_char;
    logic                               is_last;
    logic [bdasc_pkg::COUNT_W-1:0]      digit_count;

    modport source (output valid, output ascii_char, output is_last, output digit_count,
                    input ready);
    modport sink   (input valid, input ascii_char, input is_last, input digit_count,
                    output ready);
endinterface

### rtl/bdasc_cell.sv
// One BCD digit cell of the converter row: holds a digit, does add-3 and shift.
// Depends on bdasc_pkg for the command and link types.
module bdasc_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bdasc_pkg::cell_ctrl_t  ctrl,
    input  bdasc_pkg::cell_link_t  lower,
    output bdasc_pkg::cell_link_t  upper
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adjusted;

    // The carry handed upward is the top bit after the add-3 correction.
    assign adjusted    = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign upper.digit = digit_reg;
    assign upper.carry = adjusted[3];

    always_comb
    begin
        unique case (ctrl.op)
            bdasc_pkg::OP_HOLD:     digit_next = digit_reg;
            bdasc_pkg::OP_CLEAR:    digit_next = 4'd0;
            bdasc_pkg::OP_DABBLE:   digit_next = {adjusted[2:0], lower.carry};
            bdasc_pkg::OP_SHIFT_UP: digit_next = lower.digit;
            default:                digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

### rtl/bdasc_chain.sv
// Row of BCD digit cells, least significant at the bottom.
// Depends on bdasc_pkg and bdasc_cell; presents the most significant digit.
module bdasc_chain #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bdasc_pkg::cell_ctrl_t  ctrl,
    output logic [3:0]             top_digit
);

    bdasc_pkg::cell_link_t links [MAX_DIGITS];
    bdasc_pkg::cell_link_t feed  [MAX_DIGITS];

    // The bottom cell takes the next binary bit, and a zero digit on an upward shift.
    assign feed[0].digit = 4'd0;
    assign feed[0].carry = ctrl.shift_bit;

    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        if (i > 0)
        begin : g_feed
            assign feed[i] = links[i-1];
        end

        bdasc_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .lower (feed[i]),
            .upper (links[i])
        );
    end

    // The carry out of the top cell is dropped.
    assign top_digit = links[MAX_DIGITS-1].digit;

endmodule

### rtl/binary_to_decimal_ascii_core.sv
// Top level of the binary to decimal ASCII converter.
// Depends on bdasc_pkg, the two channel interfaces and bdasc_chain.
//
// Usage: the num channel takes one unsigned 64-bit value per transfer. The
// text channel returns its decimal form as ASCII digits, most significant
// first, one character per transfer, with no leading zeros; values 0 to 9
// come out as '0' followed by the digit. Every character carries the count
// of significant digits and is_last marks the final character.
// Sequence: a value goes through the digit row one double dabble step per
// binary bit, then leading zeros are shifted out of the top cell, then one
// character per cycle goes out while the receiver takes them. One value is
// handled at a time. Reset clears the sequencer and the output valid flag;
// no character is pending. When the receiver stalls, the current character
// holds in the output register and the digit row waits; the next value can
// be taken while the last character of the previous one is still waiting.
module binary_to_decimal_ascii_core #(
    parameter int MAX_DIGITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bdasc_num_if.sink            num,
    bdasc_text_if.source         text
);

    localparam logic [bdasc_pkg::COUNT_W-1:0] DIGITS_INIT =
        bdasc_pkg::COUNT_W'(MAX_DIGITS);
    localparam logic [bdasc_pkg::STEP_W-1:0] LAST_STEP =
        bdasc_pkg::STEP_W'(bdasc_pkg::VALUE_BITS - 1);
    localparam logic [bdasc_pkg::STEP_W-1:0] STEP_ONE =
        bdasc_pkg::STEP_W'(1);

    bdasc_pkg::state_t                 state_reg,     state_next;
    logic [bdasc_pkg::VALUE_BITS-1:0]  shift_reg,     shift_next;
    logic [bdasc_pkg::STEP_W-1:0]      step_reg,      step_next;
    logic [bdasc_pkg::COUNT_W-1:0]     count_reg,     count_next;
    logic [bdasc_pkg::COUNT_W-1:0]     remaining_reg, remaining_next;
    logic                              pad_reg,       pad_next;
    logic                              out_valid_reg, out_valid_next;
    logic [bdasc_pkg::CHAR_W-1:0]      out_char_reg,  out_char_next;
    logic                              out_last_reg,  out_last_next;
    logic [bdasc_pkg::COUNT_W-1:0]     out_count_reg, out_count_next;

    bdasc_pkg::cell_ctrl_t             cell_ctrl;
    logic [3:0]                        top_digit;
    logic                              out_free;

    bdasc_chain #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .top_digit (top_digit)
    );

    assign out_free  = !out_valid_reg || text.ready;
    assign num.ready = (state_reg == bdasc_pkg::ST_IDLE);

    assign text.valid       = out_valid_reg;
    assign text.ascii_char  = out_char_reg;
    assign text.is_last     = out_last_reg;
    assign text.digit_count = out_count_reg;

    always_comb
    begin
        state_next          = state_reg;
        shift_next          = shift_reg;
        step_next           = step_reg;
        count_next          = count_reg;
        remaining_next      = remaining_reg;
        pad_next            = pad_reg;
        out_valid_next      = out_valid_reg && !text.ready;
        out_char_next       = out_char_reg;
        out_last_next       = out_last_reg;
        out_count_next      = out_count_reg;
        cell_ctrl.op        = bdasc_pkg::OP_HOLD;
        cell_ctrl.shift_bit = shift_reg[bdasc_pkg::VALUE_BITS-1];

        unique case (state_reg)
            bdasc_pkg::ST_IDLE:
            begin
                if (num.valid)
                begin
                    shift_next   = num.value;
                    step_next    = '0;
                    cell_ctrl.op = bdasc_pkg::OP_CLEAR;
                    state_next   = bdasc_pkg::ST_CONVERT;
                end
            end
            bdasc_pkg::ST_CONVERT:
            begin
                cell_ctrl.op = bdasc_pkg::OP_DABBLE;
                shift_next   = {shift_reg[bdasc_pkg::VALUE_BITS-2:0], 1'b0};
                step_next    = step_reg + STEP_ONE;
                if (step_reg == LAST_STEP)
                begin
                    count_next = DIGITS_INIT;
                    state_next = bdasc_pkg::ST_SKIP;
                end
            end
            bdasc_pkg::ST_SKIP:
            begin
                // Leading zeros leave through the top cell until a nonzero digit
                // or the last digit sits there.
                if (top_digit == 4'd0 && count_reg > 5'd1)
                begin
                    cell_ctrl.op = bdasc_pkg::OP_SHIFT_UP;
                    count_next   = count_reg - 5'd1;
                end
                else
                begin
                    remaining_next = count_reg;
                    pad_next       = (count_reg == 5'd1);
                    state_next     = bdasc_pkg::ST_EMIT;
                end
            end
            bdasc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    if (pad_reg)
                    begin
                        out_char_next = bdasc_pkg::ASCII_ZERO;
                        out_last_next = 1'b0;
                        pad_next      = 1'b0;
                    end
                    else
                    begin
                        out_char_next  = bdasc_pkg::ASCII_ZERO + {2'b00, top_digit};
                        out_last_next  = (remaining_reg == 5'd1);
                        cell_ctrl.op   = bdasc_pkg::OP_SHIFT_UP;
                        remaining_next = remaining_reg - 5'd1;
                        if (remaining_reg == 5'd1)
                        begin
                            state_next = bdasc_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = bdasc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdasc_pkg::ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            remaining_reg <= '0;
            pad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            pad_reg       <= pad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_count_reg <= out_count_next;
    end

`ifndef ASSERT_OFF
    a_char_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_char_reg >= bdasc_pkg::ASCII_ZERO &&
                           out_char_reg <= bdasc_pkg::ASCII_NINE))
        else $error("output character is not a decimal digit");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg >= 5'd1 && out_count_reg <= DIGITS_INIT))
        else $error("digit count out of range");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (num.valid && num.ready) |=> (state_reg == bdasc_pkg::ST_CONVERT &&
                                      step_reg == '0))
        else $error("accepted value did not start a conversion");

    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdasc_pkg::ST_EMIT) |-> (remaining_reg != '0))
        else $error("emitting with no characters left");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !text.ready) |=> (out_valid_reg && $stable(out_char_reg)))
        else $error("pending character changed while stalled");
`endif

endmodule

### tb/binary_to_decimal_ascii_core_tb.sv
`timescale 1ns / 100ps
// Testbench of binary_to_decimal_ascii_core: directed values, then random ones,
// each checked character by character against typed text or a double dabble predictor.
// Depends on bdasc_pkg, bdasc_num_if, bdasc_text_if and the core itself.
module binary_to_decimal_ascii_core_tb;

    localparam int MAX_DIGITS   = 20;
    localparam int DIGIT_STORE  = 20;
    localparam int RANDOM_ITEMS = 480;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam int N_DIRECTED   = 15;

    typedef struct packed {
        logic [bdasc_pkg::CHAR_W-1:0]  ascii_char;
        logic                          is_last;
        logic [bdasc_pkg::COUNT_W-1:0] digit_count;
    } text_char_t;

    logic clk;
    logic rst_n;

    bdasc_num_if  num_ch ();
    bdasc_text_if text_ch ();

    binary_to_decimal_ascii_core #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .num  (num_ch),
        .text (text_ch)
    );

    text_char_t  pending_chars[$];
    int unsigned error_count;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // An empty text means the row is checked against the predictor.
    logic [bdasc_pkg::VALUE_BITS-1:0] directed_value [N_DIRECTED] = '{
        64'd0, 64'd1, 64'd7, 64'd9, 64'd10, 64'd99, 64'd100, 64'd12345,
        64'hFFFF_FFFF, 64'h8000_0000_0000_0000, 64'd9999999999999999999,
        64'd10000000000000000000, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF
    };
    string directed_text [N_DIRECTED] = '{
        "00", "01", "07", "09", "10", "", "100", "",
        "4294967295", "", "9999999999999999999",
        "10000000000000000000", "", "", "18446744073709551615"
    };
    int unsigned directed_count [N_DIRECTED] = '{
        1, 1, 1, 1, 2, 0, 3, 0, 10, 0, 19, 20, 0, 0, 20
    };

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Converts one value the way the digit row does: 64 shift-and-add-3 steps,
    // then strips leading zeros and queues one entry per character.
    function automatic void predict_decimal_text(
        input logic [bdasc_pkg::VALUE_BITS-1:0] v);
        logic [bdasc_pkg::VALUE_BITS-1:0] shreg;
        logic [3:0]                       bcd [DIGIT_STORE];
        int unsigned                      ndig;
        int unsigned                      count;
        int                               d;
        text_char_t                       entry;
        shreg = v;
        ndig  = MAX_DIGITS;
        if (ndig < 2)
            ndig = 2;
        if (ndig > DIGIT_STORE)
            ndig = DIGIT_STORE;
        for (d = 0; d < DIGIT_STORE; d++)
            bcd[d] = 4'd0;
        for (int step = 0; step < bdasc_pkg::VALUE_BITS; step++)
        begin
            for (d = 0; d < int'(ndig); d++)
                if (bcd[d] >= 4'd5)
                    bcd[d] = bcd[d] + 4'd3;
            for (d = int'(ndig) - 1; d >= 1; d--)
                bcd[d] = {bcd[d][2:0], bcd[d-1][3]};
            bcd[0] = {bcd[0][2:0], shreg[bdasc_pkg::VALUE_BITS-1]};
            shreg  = shreg << 1;
        end
        count = 1;
        for (d = int'(ndig); d >= 1; d--)
            if (bcd[d-1] != 4'd0)
            begin
                count = d;
                break;
            end
        entry.digit_count = count[bdasc_pkg::COUNT_W-1:0];
        if (count == 1)
        begin
            entry.ascii_char = bdasc_pkg::ASCII_ZERO;
            entry.is_last    = 1'b0;
            pending_chars.push_back(entry);
            entry.ascii_char = bdasc_pkg::ASCII_ZERO + bdasc_pkg::CHAR_W'(bcd[0]);
            entry.is_last    = 1'b1;
            pending_chars.push_back(entry);
        end
        else
        begin
            for (d = int'(count); d >= 1; d--)
            begin
                entry.ascii_char = bdasc_pkg::ASCII_ZERO + bdasc_pkg::CHAR_W'(bcd[d-1]);
                entry.is_last    = (d == 1);
                pending_chars.push_back(entry);
            end
        end
    endfunction

    function automatic void queue_typed_text(input string s, input int unsigned count);
        text_char_t entry;
        byte        c;
        for (int i = 0; i < s.len(); i++)
        begin
            c                 = s[i];
            entry.ascii_char  = c[bdasc_pkg::CHAR_W-1:0];
            entry.is_last     = (i == s.len() - 1);
            entry.digit_count = count[bdasc_pkg::COUNT_W-1:0];
            pending_chars.push_back(entry);
        end
    endfunction

    // Mostly random bit lengths so that short and long numbers both show up,
    // with some values at or next to a power of ten and some single digits.
    function automatic logic [bdasc_pkg::VALUE_BITS-1:0] random_value();
        logic [bdasc_pkg::VALUE_BITS-1:0] v;
        logic [bdasc_pkg::VALUE_BITS-1:0] p;
        int unsigned                      sel;
        int unsigned                      len;
        sel = $urandom_range(7);
        if (sel == 0)
        begin
            p = 64'd1;
            repeat ($urandom_range(19))
                p = p * 64'd10;
            v = p + 64'($urandom_range(2)) - 64'd1;
        end
        else if (sel == 1)
            v = 64'($urandom_range(9));
        else
        begin
            v   = {$urandom, $urandom};
            len = $urandom_range(bdasc_pkg::VALUE_BITS);
            if (len < bdasc_pkg::VALUE_BITS)
                v = v & ((64'd1 << len) - 64'd1);
        end
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_value(input logic [bdasc_pkg::VALUE_BITS-1:0] v,
                              input string typed, input int unsigned count);
        while ($urandom_range(99) < send_idle_pct)
        begin
            num_ch.valid <= 1'b0;
            @(negedge clk);
        end
        num_ch.valid <= 1'b1;
        num_ch.value <= v;
        do
            @(posedge clk);
        while (!num_ch.ready);
        if (typed.len() != 0)
            queue_typed_text(typed, count);
        else
            predict_decimal_text(v);
        @(negedge clk);
    endtask

    always @(negedge clk)
        text_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                error_count++;
                $display("%0t: extra character: expected none, actual %0d %0b %0d",
                         $time, text_ch.ascii_char, text_ch.is_last, text_ch.digit_count);
            end
            else
            begin
                text_char_t want;
                want = pending_chars.pop_front();
                if (text_ch.ascii_char !== want.ascii_char)
                begin
                    error_count++;
                    $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                             $time, want.ascii_char, text_ch.ascii_char);
                end
                if (text_ch.is_last !== want.is_last)
                begin
                    error_count++;
                    $display("%0t: is_last mismatch: expected %0b, actual %0b",
                             $time, want.is_last, text_ch.is_last);
                end
                if (text_ch.digit_count !== want.digit_count)
                begin
                    error_count++;
                    $display("%0t: digit_count mismatch: expected %0d, actual %0d",
                             $time, want.digit_count, text_ch.digit_count);
                end
            end
        end
    end

    // Watchdog: the run ends if neither channel sees a transfer for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        num_ch.valid  = 1'b0;
        num_ch.value  = '0;
        send_idle_pct = 30;
        recv_idle_pct = 64;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_value(directed_value[i], directed_text[i], directed_count[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 30;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_value(random_value(), "", 0);
        end
        num_ch.valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
